[rtl/mfrqe_pkg.sv]
// Shared types, constants and transform-state helpers for the flip/rotate/quadrant engine.
`timescale 1ns / 1ps
package mfrqe_pkg;

   // Default largest half dimension of the stored array
   localparam int MAX_HALF_DEF = 64;
   // Fixed field widths
   localparam int PIXEL_BITS   = 16;
   localparam int HALF_W       = 7;
   localparam int COORD_W      = 7;
   localparam int DIM_W        = 8;
   localparam int CSR_INDEX_W  = 1;

   // Request kinds
   localparam logic [1:0] REQ_WRITE   = 2'd0;
   localparam logic [1:0] REQ_OPERATE = 2'd1;
   localparam logic [1:0] REQ_READ    = 2'd2;

   // Operation codes
   localparam logic [2:0] OP_FLIP_V   = 3'd0;
   localparam logic [2:0] OP_MIRROR   = 3'd1;
   localparam logic [2:0] OP_ROT_CW   = 3'd2;
   localparam logic [2:0] OP_ROT_CCW  = 3'd3;
   localparam logic [2:0] OP_QUAD_CW  = 3'd4;
   localparam logic [2:0] OP_QUAD_CCW = 3'd5;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_ROWS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_COLS = 1'd1;

   typedef struct packed {
      logic [1:0]            req_type;
      logic [COORD_W-1:0]    row;
      logic [COORD_W-1:0]    col;
      logic [PIXEL_BITS-1:0] pixel;
      logic [2:0]            op_code;
   } req_item_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] read_value;
      logic                  error;
      logic [DIM_W-1:0]      cur_rows;
      logic [DIM_W-1:0]      cur_cols;
   } rsp_item_type;

   // Composed view map: orient bit0 row flip, bit1 column flip, bit2 transpose
   typedef struct packed {
      logic [2:0] orient;
      logic [1:0] quad;
   } view_state_type;

   // Compose one operation onto the current view map
   function automatic view_state_type apply_op(view_state_type s, logic [2:0] op);
      view_state_type n;
      logic           t;
      logic           refl;
      logic [2:0]     flip_v;
      logic [2:0]     flip_h;
      n      = s;
      t      = s.orient[2];
      refl   = s.orient[2] ^ s.orient[1] ^ s.orient[0];
      flip_v = t ? 3'd2 : 3'd1;
      flip_h = t ? 3'd1 : 3'd2;
      case (op)
         OP_FLIP_V:   n.orient = s.orient ^ flip_v;
         OP_MIRROR:   n.orient = s.orient ^ flip_h;
         OP_ROT_CW:   n.orient = s.orient ^ (flip_v | 3'd4);
         OP_ROT_CCW:  n.orient = s.orient ^ (flip_h | 3'd4);
         OP_QUAD_CW:  n.quad   = s.quad + (refl ? 2'd3 : 2'd1);
         OP_QUAD_CCW: n.quad   = s.quad + (refl ? 2'd1 : 2'd3);
         default:     n        = s;
      endcase
      return n;
   endfunction

endpackage

[rtl/mfrqe_addr_map.sv]
// View coordinate to base pixel address translation through the composed view map.
`timescale 1ns / 1ps
module mfrqe_addr_map #(
   parameter int MAX_HALF = mfrqe_pkg::MAX_HALF_DEF,
   localparam int ADDR_W = $clog2(4 * MAX_HALF * MAX_HALF)
) (
   input  mfrqe_pkg::view_state_type      view,
   input  logic [mfrqe_pkg::HALF_W-1:0]   half_rows,
   input  logic [mfrqe_pkg::HALF_W-1:0]   half_cols,
   input  logic [mfrqe_pkg::COORD_W-1:0]  row,
   input  logic [mfrqe_pkg::COORD_W-1:0]  col,
   output logic [ADDR_W-1:0]              addr
);
   import mfrqe_pkg::*;

   localparam int SIDE = 2 * MAX_HALF;

   logic [COORD_W-1:0] u;
   logic [COORD_W-1:0] v;
   logic [DIM_W-1:0]   full_rows;
   logic [DIM_W-1:0]   full_cols;
   logic [DIM_W-1:0]   a_rev;
   logic [DIM_W-1:0]   b_rev;
   logic [COORD_W-1:0] a;
   logic [COORD_W-1:0] b;
   logic               qr;
   logic               qc;
   logic [1:0]         pos;
   logic [1:0]         src;
   logic [COORD_W-1:0] oa;
   logic [COORD_W-1:0] ob;
   logic [COORD_W-1:0] br;
   logic [COORD_W-1:0] bc;

   // Undo transpose and flips
   always_comb begin
      u         = view.orient[2] ? col : row;
      v         = view.orient[2] ? row : col;
      full_rows = {1'b0, half_rows} << 1;
      full_cols = {1'b0, half_cols} << 1;
      a_rev     = full_rows - 8'd1 - {1'b0, u};
      b_rev     = full_cols - 8'd1 - {1'b0, v};
      a         = view.orient[0] ? a_rev[COORD_W-1:0] : u;
      b         = view.orient[1] ? b_rev[COORD_W-1:0] : v;
   end

   // Undo the quadrant shift
   always_comb begin
      qr  = (a >= half_rows);
      qc  = (b >= half_cols);
      pos = qr ? (qc ? 2'd2 : 2'd3) : (qc ? 2'd1 : 2'd0);
      src = pos - view.quad;
      oa  = a - (qr ? half_rows : '0);
      ob  = b - (qc ? half_cols : '0);
      br  = oa + (src[1] ? half_rows : '0);
      bc  = ob + ((src[1] ^ src[0]) ? half_cols : '0);
   end

   // Row-major base address
   assign addr = ADDR_W'(br) * ADDR_W'(SIDE) + ADDR_W'(bc);

endmodule

[rtl/matrix_flip_rotate_quadrant_engine_core.sv]
// Top level of the flip/rotate/quadrant engine: request stage, pixel memory, response stage.
`timescale 1ns / 1ps
// A request passes through the request register, then the registered pixel memory read
// and the response register, before its response is driven. Throughput: one request per
// cycle; busy stays low. Reset clears the view map to identity and both half sizes to one;
// the pixel store is not cleared and holds unknown data until written. The receiver cannot
// stall.
module matrix_flip_rotate_quadrant_engine_core #(
   parameter int MAX_HALF = mfrqe_pkg::MAX_HALF_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  mfrqe_pkg::req_item_type            req_data,
   output logic                               rsp_strobe,
   output mfrqe_pkg::rsp_item_type            rsp_data,
   input  logic                               csr_we,
   input  logic [mfrqe_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mfrqe_pkg::HALF_W-1:0]       csr_wdata
);
   import mfrqe_pkg::*;

   localparam int DEPTH  = 4 * MAX_HALF * MAX_HALF;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [HALF_W-1:0]     half_rows_ff;
   logic [HALF_W-1:0]     half_cols_ff;
   logic [HALF_W-1:0]     half_clamped;
   view_state_type        view_ff;
   view_state_type        view_in;
   logic                  accept;

   logic                  s1_valid_ff;
   req_item_type          s1_req_ff;

   logic [DIM_W-1:0]      cur_rows;
   logic [DIM_W-1:0]      cur_cols;
   logic                  is_access;
   logic                  in_view;
   logic [ADDR_W-1:0]     addr;

   logic [PIXEL_BITS-1:0] mem [DEPTH];
   logic [PIXEL_BITS-1:0] rdata_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_error_ff;
   logic                  rsp_read_ff;
   logic [DIM_W-1:0]      rsp_rows_ff;
   logic [DIM_W-1:0]      rsp_cols_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Clamp register writes into the legal half-size range
   always_comb begin
      if (csr_wdata == '0) begin
         half_clamped = HALF_W'(1);
      end else if (csr_wdata > HALF_W'(MAX_HALF)) begin
         half_clamped = HALF_W'(MAX_HALF);
      end else begin
         half_clamped = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_rows_ff <= HALF_W'(1);
         half_cols_ff <= HALF_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HALF_ROWS: half_rows_ff <= half_clamped;
            CSR_HALF_COLS: half_cols_ff <= half_clamped;
            default: ;
         endcase
      end
   end

   // Compose operations into the view map as they are taken
   always_comb begin
      view_in = view_ff;
      if (accept && req_data.req_type == REQ_OPERATE) begin
         view_in = apply_op(view_ff, req_data.op_code);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         view_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         view_ff     <= view_in;
         s1_valid_ff <= accept;
      end
   end

   // Hold the taken request
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_data;
      end
   end

   // Current view size and range check; view_ff already includes this request's operation
   always_comb begin
      cur_rows  = view_ff.orient[2] ? {half_cols_ff, 1'b0} : {half_rows_ff, 1'b0};
      cur_cols  = view_ff.orient[2] ? {half_rows_ff, 1'b0} : {half_cols_ff, 1'b0};
      is_access = (s1_req_ff.req_type == REQ_WRITE) || (s1_req_ff.req_type == REQ_READ);
      in_view   = ({1'b0, s1_req_ff.row} < cur_rows) && ({1'b0, s1_req_ff.col} < cur_cols);
   end

   mfrqe_addr_map #(
      .MAX_HALF(MAX_HALF)
   ) u_addr_map (
      .view      (view_ff),
      .half_rows (half_rows_ff),
      .half_cols (half_cols_ff),
      .row       (s1_req_ff.row),
      .col       (s1_req_ff.col),
      .addr      (addr)
   );

   // Pixel memory: at most one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (s1_valid_ff && in_view && s1_req_ff.req_type == REQ_WRITE) begin
         mem[addr] <= s1_req_ff.pixel;
      end
      if (s1_valid_ff) begin
         rdata_ff <= mem[addr];
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rsp_error_ff <= is_access && !in_view;
         rsp_read_ff  <= (s1_req_ff.req_type == REQ_READ) && in_view;
         rsp_rows_ff  <= cur_rows;
         rsp_cols_ff  <= cur_cols;
      end
   end

   // Drive the response; drop read data for anything but a good read
   assign rsp_strobe          = rsp_valid_ff;
   assign rsp_data.read_value = rsp_read_ff ? rdata_ff : '0;
   assign rsp_data.error      = rsp_error_ff;
   assign rsp_data.cur_rows   = rsp_rows_ff;
   assign rsp_data.cur_cols   = rsp_cols_ff;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the flip/rotate/quadrant engine: directed and random requests.
`timescale 1ns / 1ps
module testbench;
   import mfrqe_pkg::*;

   localparam int SIDE        = 2 * MAX_HALF_DEF;
   localparam int STALL_LIMIT = 2000;
   localparam int SHOW_LIMIT  = 40;

   // Codes the block must ignore
   localparam logic [1:0] REQ_UNUSED  = 2'd3;
   localparam logic [2:0] OP_RESERVED_A = 3'd6;
   localparam logic [2:0] OP_RESERVED_B = 3'd7;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   start      = 1'b0;
   logic                   busy;
   req_item_type           req_data   = '0;
   logic                   rsp_strobe;
   rsp_item_type           rsp_data;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [HALF_W-1:0]      csr_wdata  = '0;

   // Mirror of the view map and the pixel store, by base address
   int                     half_rows_cfg = 1;
   int                     half_cols_cfg = 1;
   logic [2:0]             view_orient   = 3'd0;
   logic [1:0]             view_quad     = 2'd0;
   logic [PIXEL_BITS-1:0]  pixel_shadow [SIDE*SIDE];
   bit                     written_map  [SIDE*SIDE];
   rsp_item_type           expected_rsp [$];

   int idle_pct      = 11;
   int last_row      = 0;
   int last_col      = 0;
   int stall_cycles  = 0;
   int mismatches    = 0;
   int requests_sent = 0;
   int reads_done    = 0;
   int writes_done   = 0;
   int transforms    = 0;
   int out_of_view   = 0;
   int size_settings = 0;

   matrix_flip_rotate_quadrant_engine_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int clamp_half(input logic [HALF_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_HALF_DEF) return MAX_HALF_DEF;
      return int'(raw);
   endfunction

   function automatic int view_rows();
      return view_orient[2] ? 2 * half_cols_cfg : 2 * half_rows_cfg;
   endfunction

   function automatic int view_cols();
      return view_orient[2] ? 2 * half_rows_cfg : 2 * half_cols_cfg;
   endfunction

   // Translate a view coordinate into the fixed base address of the pixel
   function automatic int base_address(input int r, input int c);
      int u, v, a, b, qr, qc, pos, src, br, bc;
      u   = view_orient[2] ? c : r;
      v   = view_orient[2] ? r : c;
      a   = view_orient[0] ? 2 * half_rows_cfg - 1 - u : u;
      b   = view_orient[1] ? 2 * half_cols_cfg - 1 - v : v;
      qr  = (a >= half_rows_cfg) ? 1 : 0;
      qc  = (b >= half_cols_cfg) ? 1 : 0;
      pos = qr ? (qc ? 2 : 3) : (qc ? 1 : 0);
      src = (pos - view_quad) & 3;
      br  = a - qr * half_rows_cfg + ((src >= 2) ? half_rows_cfg : 0);
      bc  = b - qc * half_cols_cfg + ((src == 1 || src == 2) ? half_cols_cfg : 0);
      return br * SIDE + bc;
   endfunction

   // Compose one transform onto the view map; reflections reverse quadrant moves
   function automatic void apply_view_change(input logic [2:0] op);
      logic       reflected;
      logic [2:0] vert;
      logic [2:0] horiz;
      reflected = ^view_orient;
      vert      = view_orient[2] ? 3'b010 : 3'b001;
      horiz     = view_orient[2] ? 3'b001 : 3'b010;
      case (op)
         OP_FLIP_V:   view_orient = view_orient ^ vert;
         OP_MIRROR:   view_orient = view_orient ^ horiz;
         OP_ROT_CW:   view_orient = view_orient ^ (vert | 3'b100);
         OP_ROT_CCW:  view_orient = view_orient ^ (horiz | 3'b100);
         OP_QUAD_CW:  view_quad   = view_quad + (reflected ? 2'd3 : 2'd1);
         OP_QUAD_CCW: view_quad   = view_quad + (reflected ? 2'd1 : 2'd3);
         default: ;
      endcase
   endfunction

   // Work out the response to one accepted request and update the mirror
   function automatic rsp_item_type predict_response(input req_item_type item);
      rsp_item_type rsp;
      int           rows, cols, addr;
      rsp = '0;
      if (item.req_type == REQ_OPERATE) begin
         apply_view_change(item.op_code);
         transforms++;
      end
      rows         = view_rows();
      cols         = view_cols();
      rsp.cur_rows = DIM_W'(rows);
      rsp.cur_cols = DIM_W'(cols);
      if (item.req_type == REQ_WRITE || item.req_type == REQ_READ) begin
         if (item.row >= rows || item.col >= cols) begin
            rsp.error = 1'b1;
            out_of_view++;
         end else begin
            addr = base_address(int'(item.row), int'(item.col));
            if (item.req_type == REQ_WRITE) begin
               pixel_shadow[addr] = item.pixel;
               written_map[addr]  = 1'b1;
               writes_done++;
            end else begin
               rsp.read_value = pixel_shadow[addr];
               reads_done++;
            end
         end
      end
      return rsp;
   endfunction

   function automatic req_item_type make_request(input logic [1:0] kind, input int r,
                                                 input int c, input int px,
                                                 input logic [2:0] op);
      req_item_type item;
      item.req_type = kind;
      item.row      = COORD_W'(r);
      item.col      = COORD_W'(c);
      item.pixel    = PIXEL_BITS'(px);
      item.op_code  = op;
      return item;
   endfunction

   // Build one random request; reads only target pixels written before
   function automatic req_item_type random_request();
      req_item_type item;
      int           rows, cols, pick, tries;
      bit           found;
      rows          = view_rows();
      cols          = view_cols();
      pick          = $urandom_range(99);
      found         = 1'b0;
      item.req_type = REQ_WRITE;
      item.row      = COORD_W'($urandom);
      item.col      = COORD_W'($urandom);
      item.pixel    = PIXEL_BITS'($urandom);
      item.op_code  = 3'($urandom);
      if (pick < 12) begin
         item.req_type = REQ_OPERATE;
         if ($urandom_range(15) != 0) item.op_code = 3'($urandom_range(5));
      end else if (pick < 15) begin
         item.req_type = REQ_UNUSED;
      end else if (pick < 21) begin
         // full coordinate range, mostly outside the view; never read an unwritten pixel
         item.req_type = $urandom_range(1) ? REQ_READ : REQ_WRITE;
         if (item.req_type == REQ_READ && item.row < rows && item.col < cols &&
             !written_map[base_address(int'(item.row), int'(item.col))])
            item.req_type = REQ_WRITE;
      end else begin
         if (pick >= 60) begin
            if ($urandom_range(2) == 0 && last_row < rows && last_col < cols &&
                written_map[base_address(last_row, last_col)]) begin
               item.row = COORD_W'(last_row);
               item.col = COORD_W'(last_col);
               found    = 1'b1;
            end
            for (tries = 0; tries < 16 && !found; tries++) begin
               item.row = COORD_W'($urandom_range(rows - 1));
               item.col = COORD_W'($urandom_range(cols - 1));
               found    = written_map[base_address(int'(item.row), int'(item.col))];
            end
         end
         if (found) begin
            item.req_type = REQ_READ;
         end else begin
            item.row = COORD_W'($urandom_range(rows - 1));
            item.col = COORD_W'($urandom_range(cols - 1));
            last_row = int'(item.row);
            last_col = int'(item.col);
         end
      end
      return item;
   endfunction

   // Present one request, hold it until taken, then idle at random
   task automatic send_request(input req_item_type item);
      rsp_item_type want;
      req_data <= item;
      start    <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      want = predict_response(item);
      expected_rsp.insert(expected_rsp.size(), want);
      requests_sent++;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_until_drained();
      start <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   // Write both half sizes once the block has gone quiet
   task automatic write_half_sizes(input logic [HALF_W-1:0] rows_half,
                                   input logic [HALF_W-1:0] cols_half);
      wait_until_drained();
      csr_we    <= 1'b1;
      csr_index <= CSR_HALF_ROWS;
      csr_wdata <= rows_half;
      @(posedge clock);
      half_rows_cfg = clamp_half(rows_half);
      csr_index <= CSR_HALF_COLS;
      csr_wdata <= cols_half;
      @(posedge clock);
      half_cols_cfg = clamp_half(cols_half);
      csr_we <= 1'b0;
      size_settings++;
   endtask

   // Reset sizes: fill the 2x2 view, apply every transform, hit the ignored codes
   task automatic test_default_view();
      send_request(make_request(REQ_WRITE, 0, 0, 16'hFFFF, OP_FLIP_V));
      send_request(make_request(REQ_WRITE, 0, 1, 16'h0000, OP_RESERVED_B));
      send_request(make_request(REQ_WRITE, 1, 0, 16'hA5A5, OP_FLIP_V));
      send_request(make_request(REQ_WRITE, 1, 1, 16'h5A5A, OP_FLIP_V));
      send_request(make_request(REQ_READ, 0, 1, 16'hFFFF, OP_FLIP_V));
      send_request(make_request(REQ_OPERATE, 0, 0, 0, OP_FLIP_V));
      send_request(make_request(REQ_READ, 0, 0, 0, OP_FLIP_V));
      send_request(make_request(REQ_OPERATE, 0, 0, 0, OP_MIRROR));
      send_request(make_request(REQ_READ, 0, 1, 0, OP_FLIP_V));
      send_request(make_request(REQ_OPERATE, 0, 0, 0, OP_ROT_CW));
      send_request(make_request(REQ_READ, 1, 0, 0, OP_FLIP_V));
      send_request(make_request(REQ_OPERATE, 0, 0, 0, OP_ROT_CCW));
      send_request(make_request(REQ_OPERATE, 0, 0, 0, OP_QUAD_CW));
      send_request(make_request(REQ_READ, 0, 0, 0, OP_FLIP_V));
      send_request(make_request(REQ_OPERATE, 0, 0, 0, OP_QUAD_CCW));
      send_request(make_request(REQ_READ, 1, 1, 0, OP_FLIP_V));
      send_request(make_request(REQ_OPERATE, 127, 127, 16'hFFFF, OP_RESERVED_A));
      send_request(make_request(REQ_OPERATE, 0, 0, 0, OP_RESERVED_B));
      send_request(make_request(REQ_UNUSED, 127, 127, 16'hFFFF, OP_RESERVED_B));
      send_request(make_request(REQ_WRITE, 2, 0, 16'h1234, OP_FLIP_V));
      send_request(make_request(REQ_READ, 0, 127, 0, OP_FLIP_V));
      send_request(make_request(REQ_READ, 127, 127, 0, OP_FLIP_V));
   endtask

   // Out-of-range half sizes clamp to the legal limits
   task automatic test_size_limits();
      write_half_sizes(7'd0, 7'd127);
      send_request(make_request(REQ_WRITE, view_rows() - 1, view_cols() - 1, 16'h8001,
                                OP_FLIP_V));
      send_request(make_request(REQ_READ, view_rows() - 1, view_cols() - 1, 0, OP_FLIP_V));
      send_request(make_request(REQ_READ, view_rows(), 0, 0, OP_FLIP_V));
      write_half_sizes(7'd127, 7'd65);
      send_request(make_request(REQ_WRITE, view_rows() - 1, 0, 16'h7FFE, OP_FLIP_V));
      send_request(make_request(REQ_READ, view_rows() - 1, 0, 0, OP_FLIP_V));
      send_request(make_request(REQ_WRITE, 0, view_cols(), 16'h0F0F, OP_FLIP_V));
   endtask

   // Random requests over several array sizes, small ones most of the time
   task automatic test_random_traffic(input int pct, input int phase);
      int seg, count;
      idle_pct = pct;
      for (seg = 0; seg < 4; seg++) begin
         case (seg)
            0: begin
               write_half_sizes(HALF_W'($urandom_range(1, 3)), HALF_W'($urandom_range(1, 3)));
               count = 150;
            end
            1: begin
               write_half_sizes(HALF_W'($urandom_range(1, 8)), HALF_W'($urandom_range(1, 8)));
               count = 150;
            end
            2: begin
               write_half_sizes(HALF_W'($urandom_range(0, 127)),
                                HALF_W'($urandom_range(0, 127)));
               count = 80;
            end
            default: begin
               if (phase == 0)      write_half_sizes(7'd64, 7'd64);
               else if (phase == 1) write_half_sizes(7'd0, 7'd127);
               else                 write_half_sizes(7'd127, 7'd1);
               count = 60;
            end
         endcase
         repeat (count) send_request(random_request());
      end
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= SHOW_LIMIT)
            $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
   endfunction

   // Compare each response with the oldest prediction
   always @(posedge clock) begin : check_responses
      rsp_item_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
               $display("%0t ns: unexpected response, expected none actual %h",
                        $time, rsp_data);
         end else begin
            want = expected_rsp.pop_front();
            check_field("read_value", 32'(want.read_value), 32'(rsp_data.read_value));
            check_field("error", 32'(want.error), 32'(rsp_data.error));
            check_field("cur_rows", 32'(want.cur_rows), 32'(rsp_data.cur_rows));
            check_field("cur_cols", 32'(want.cur_cols), 32'(rsp_data.cur_cols));
         end
      end
   end

   // Stop the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe === 1'b1) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == STALL_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_view();
      test_size_limits();
      test_random_traffic(11, 0);
      test_random_traffic(86, 1);
      test_random_traffic(0, 2);
      wait_until_drained();
      repeat (8) @(posedge clock);
      $display("Covered %0d requests: %0d reads, %0d writes, %0d transforms, %0d off-view",
               requests_sent, reads_done, writes_done, transforms, out_of_view);
      $display("Across %0d size settings with request idle rates of 11, 86 and 0 percent",
               size_settings);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/mfrqe_pkg.sv
rtl/mfrqe_addr_map.sv
rtl/matrix_flip_rotate_quadrant_engine_core.sv
tb/testbench.sv
